FILE: src/dpcm_audio_unit_decoder_core_assert.svh
// assertion macros shared by the decoder checks
`ifndef DPCM_AUDIO_UNIT_DECODER_CORE_ASSERT_SVH
`define DPCM_AUDIO_UNIT_DECODER_CORE_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define DPCM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dpcm decoder check failed");

// condition that must never be seen outside reset
`define DPCM_NEVER(label, cond) \
  `DPCM_ASSERT(label, !(cond))

`endif

FILE: src/dpcm_pkg.sv
// shared types, codes and level tables of the dpcm audio decoder
`default_nettype none

package dpcm_pkg;

  // request kinds carried in tuser
  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_PACK_LEVEL = 3'd0;
  localparam logic [2:0] CFG_STEREO     = 3'd1;
  localparam logic [2:0] CFG_ZERO_RUN   = 3'd2;
  localparam logic [2:0] CFG_SKIP       = 3'd3;
  localparam logic [2:0] CFG_KEEP       = 3'd4;
  localparam logic [2:0] CFG_UNIT_LEN   = 3'd5;

  // mode codes of the 3-bit prefix
  localparam logic [2:0] MODE_ZERO = 3'd0;
  localparam logic [2:0] MODE_WIDE = 3'd7;

  // control group handed to the sample decoder
  typedef struct packed {
    logic [2:0] level;
    logic       zero_run_en;
  } dec_cfg_t;

  // levels above five decode as five
  function automatic logic [2:0] level_clamp(input logic [2:0] lv);
    level_clamp = (lv > 3'd5) ? 3'd5 : lv;
  endfunction

  // width of a normal delta field
  function automatic logic [3:0] delta_width(input logic [2:0] lv);
    unique case (lv)
      3'd0:    delta_width = 4'd5;
      3'd1:    delta_width = 4'd4;
      3'd2:    delta_width = 4'd3;
      3'd3:    delta_width = 4'd6;
      3'd4:    delta_width = 4'd7;
      default: delta_width = 4'd8;
    endcase
  endfunction

  // shift base added to the mode code
  function automatic logic [3:0] delta_shift_base(input logic [2:0] lv);
    unique case (lv)
      3'd0:    delta_shift_base = 4'd2;
      3'd1:    delta_shift_base = 4'd3;
      3'd2:    delta_shift_base = 4'd4;
      default: delta_shift_base = 4'd1;
    endcase
  endfunction

  // width of the wide delta field
  function automatic logic [3:0] wide_width(input logic [2:0] lv);
    unique case (lv)
      3'd1:    wide_width = 4'd7;
      3'd2:    wide_width = 4'd6;
      default: wide_width = 4'd8;
    endcase
  endfunction

  // fixed shift of the wide delta
  function automatic logic [3:0] wide_shift(input logic [2:0] lv);
    unique case (lv)
      3'd1:    wide_shift = 4'd10;
      3'd2:    wide_shift = 4'd11;
      default: wide_shift = 4'd9;
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: src/dpcm_audio_unit_decoder_core.sv
// Delta-coded 16-bit audio decoder, one sample per beat. An input beat lands
// in an input register; once the result register is free, one pass of decode
// logic (prefix decode, shift and one 32-bit add) updates the channel predictors
// and counters and fills the result register, and one item can be taken every
// cycle while the result side keeps up.
// The input register and the result register decouple the two sides: a new
// beat is taken while a finished result still waits. Configuration is always
// ready and should be written only while no item is in flight.
`default_nettype none

module dpcm_audio_unit_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,  // bit_window[15:0], initial_left[31:16],
                                      // initial_right[47:32]
  input  wire logic        in_tuser,  // req_type
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata, // sample[15:0], bits_used[19:16], kept[20],
                                      // done_res[21], zero[23:22]
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // configuration registers
  logic [2:0]  level_r;
  logic        stereo_r;
  logic        zr_en_r;
  logic [15:0] skip_r;
  logic [15:0] keep_r;
  logic [15:0] unit_len_r;

  // input register
  logic        in_v_r;
  logic        req_r;
  logic [15:0] win_r;
  logic [15:0] init_l_r;
  logic [15:0] init_r_r;

  // decoder state
  logic [31:0] pred_l_r, pred_l_nxt;
  logic [31:0] pred_rt_r, pred_rt_nxt;
  logic [7:0]  run_r, run_nxt;
  logic [16:0] idx_r, idx_nxt;
  logic [16:0] kept_tot_r, kept_tot_nxt;
  logic        stop_r, stop_nxt;

  // result register
  logic        out_v_r;
  logic [15:0] smp_r, smp_nxt;
  logic [3:0]  bits_r, bits_nxt;
  logic        kept_r, kept_nxt;
  logic        done_r, done_nxt;

  logic               proc;
  logic               right;
  logic [31:0]        pred_sel;
  logic [31:0]        pred_dec;
  logic [7:0]         run_dec;
  logic [3:0]         pos_dec;
  dpcm_pkg::dec_cfg_t dcfg;

  assign cfg_ready = 1'b1;

  // configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= 3'd0;
      stereo_r   <= 1'b0;
      zr_en_r    <= 1'b0;
      skip_r     <= 16'd0;
      keep_r     <= 16'hffff;
      unit_len_r <= 16'hffff;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dpcm_pkg::CFG_PACK_LEVEL: level_r    <= cfg_data[2:0];
        dpcm_pkg::CFG_STEREO:     stereo_r   <= cfg_data[0];
        dpcm_pkg::CFG_ZERO_RUN:   zr_en_r    <= cfg_data[0];
        dpcm_pkg::CFG_SKIP:       skip_r     <= cfg_data;
        dpcm_pkg::CFG_KEEP:       keep_r     <= cfg_data;
        dpcm_pkg::CFG_UNIT_LEN:   unit_len_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake between the two register stages
  assign proc       = in_v_r && (!out_v_r || out_tready);
  assign in_tready  = !in_v_r || proc;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, done_r, kept_r, bits_r, smp_r};

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r    <= in_tuser;
      win_r    <= in_tdata[15:0];
      init_l_r <= in_tdata[31:16];
      init_r_r <= in_tdata[47:32];
    end
  end

  // channel select and sample decode
  assign right     = stereo_r && idx_r[0];
  assign pred_sel  = right ? pred_rt_r : pred_l_r;
  assign dcfg.level       = level_r;
  assign dcfg.zero_run_en = zr_en_r;

  dpcm_dec u_dec (
    .win    (win_r),
    .pred_i (pred_sel),
    .run_i  (run_r),
    .cfg    (dcfg),
    .pred_o (pred_dec),
    .run_o  (run_dec),
    .pos_o  (pos_dec)
  );

  // state and result update for the item in the input register
  always_comb begin
    pred_l_nxt   = pred_l_r;
    pred_rt_nxt  = pred_rt_r;
    run_nxt      = run_r;
    idx_nxt      = idx_r;
    kept_tot_nxt = kept_tot_r;
    stop_nxt     = stop_r;
    smp_nxt      = smp_r;
    bits_nxt     = bits_r;
    kept_nxt     = kept_r;
    done_nxt     = done_r;
    if (proc) begin
      if (req_r == dpcm_pkg::REQ_START) begin
        pred_l_nxt   = {{16{init_l_r[15]}}, init_l_r};
        pred_rt_nxt  = {{16{init_r_r[15]}}, init_r_r};
        run_nxt      = 8'd0;
        idx_nxt      = 17'd0;
        kept_tot_nxt = 17'd0;
        stop_nxt     = 1'b0;
        smp_nxt      = 16'd0;
        bits_nxt     = 4'd0;
        kept_nxt     = 1'b0;
        done_nxt     = 1'b0;
      end else if (stop_r || (idx_r >= {1'b0, unit_len_r})) begin
        stop_nxt = 1'b1;
        smp_nxt  = 16'd0;
        bits_nxt = 4'd0;
        kept_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (right) begin
          pred_rt_nxt = pred_dec;
        end else begin
          pred_l_nxt = pred_dec;
        end
        run_nxt  = run_dec;
        kept_nxt = 1'b0;
        if (idx_r >= {1'b0, skip_r}) begin
          if (kept_tot_r < {1'b0, keep_r}) begin
            kept_nxt     = 1'b1;
            kept_tot_nxt = kept_tot_r + 17'd1;
          end else begin
            stop_nxt = 1'b1;
          end
        end
        idx_nxt = idx_r + 17'd1;
        if (idx_nxt >= {1'b0, unit_len_r}) begin
          stop_nxt = 1'b1;
        end
        smp_nxt  = pred_dec[15:0];
        bits_nxt = pos_dec;
        done_nxt = stop_nxt;
      end
    end
  end

  // decoder state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pred_l_r   <= 32'd0;
      pred_rt_r  <= 32'd0;
      run_r      <= 8'd0;
      idx_r      <= 17'd0;
      kept_tot_r <= 17'd0;
      stop_r     <= 1'b0;
    end else begin
      pred_l_r   <= pred_l_nxt;
      pred_rt_r  <= pred_rt_nxt;
      run_r      <= run_nxt;
      idx_r      <= idx_nxt;
      kept_tot_r <= kept_tot_nxt;
      stop_r     <= stop_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    smp_r  <= smp_nxt;
    bits_r <= bits_nxt;
    kept_r <= kept_nxt;
    done_r <= done_nxt;
  end

endmodule

`default_nettype wire

FILE: src/dpcm_dec.sv
// single-sample decoder: mode prefix, zero run, delta apply
`default_nettype none

module dpcm_dec (
  input  wire logic [15:0]              win,
  input  wire logic [31:0]              pred_i,
  input  wire logic [7:0]               run_i,
  input  wire dpcm_pkg::dec_cfg_t       cfg,
  output logic      [31:0]              pred_o,
  output logic      [7:0]               run_o,
  output logic      [3:0]               pos_o
);

  logic [2:0]  lv;
  logic [2:0]  mode;
  logic [3:0]  dw;
  logic [3:0]  dsh;
  logic [3:0]  ww;
  logic [3:0]  wsh;
  logic [7:0]  dmask;
  logic [7:0]  wmask;
  logic [7:0]  dfld;
  logic [7:0]  wfld;
  logic        dsign;
  logic        wsign;
  logic [31:0] dmag;
  logic [31:0] wmag;
  logic [31:0] dval;
  logic [31:0] wval;

  assign lv   = dpcm_pkg::level_clamp(cfg.level);
  assign mode = win[2:0];
  assign dw   = dpcm_pkg::delta_width(lv);
  assign dsh  = 4'(dpcm_pkg::delta_shift_base(lv) + {1'b0, mode});
  assign ww   = dpcm_pkg::wide_width(lv);
  assign wsh  = dpcm_pkg::wide_shift(lv);

  // normal delta field follows the mode code
  assign dmask = 8'((9'd1 << dw) - 9'd1);
  assign dfld  = win[10:3] & dmask;
  assign dsign = dfld[3'(dw - 4'd1)];
  assign dmag  = {24'd0, dfld & (dmask >> 1)};
  assign dval  = dmag << dsh;

  // wide delta field follows the mode code and one escape bit
  assign wmask = 8'((9'd1 << ww) - 9'd1);
  assign wfld  = win[11:4] & wmask;
  assign wsign = wfld[3'(ww - 4'd1)];
  assign wmag  = {24'd0, wfld & (wmask >> 1)};
  assign wval  = wmag << wsh;

  // pick the coding of this sample
  always_comb begin
    pred_o = pred_i;
    run_o  = run_i;
    pos_o  = 4'd0;
    if (run_i != 8'd0) begin
      run_o = run_i - 8'd1;
    end else if (mode == dpcm_pkg::MODE_ZERO) begin
      pos_o = 4'd3;
      if (cfg.zero_run_en) begin
        if (!win[3]) begin
          run_o = 8'd0;
          pos_o = 4'd4;
        end else if (win[5:4] != 2'b11) begin
          run_o = {6'd0, win[5:4]};
          pos_o = 4'd6;
        end else begin
          run_o = win[13:6];
          pos_o = 4'd14;
        end
      end
    end else if (mode != dpcm_pkg::MODE_WIDE) begin
      pos_o  = 4'(dw + 4'd3);
      pred_o = dsign ? (pred_i - dval) : (pred_i + dval);
    end else if (!win[3]) begin
      pos_o  = 4'(ww + 4'd4);
      pred_o = wsign ? (pred_i - wval) : (pred_i + wval);
    end else begin
      pos_o  = 4'd4;
      pred_o = 32'd0;
    end
  end

endmodule

`default_nettype wire

FILE: src/dpcm_chk.sv
// port-level checks of the decoder, bound to the top level
`default_nettype none

`include "dpcm_audio_unit_decoder_core_assert.svh"

module dpcm_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);

  logic [3:0] bits_seen;
  logic       bits_bad;

  assign bits_seen = out_tdata[19:16];

  // bit counts that no coding can produce
  always_comb begin
    unique case (bits_seen)
      4'd1, 4'd2, 4'd5, 4'd13, 4'd15: bits_bad = 1'b1;
      default:                        bits_bad = 1'b0;
    endcase
  end

  // a stalled result beat holds
  `DPCM_ASSERT(a_out_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))

  // each accepted input beat is followed by a valid result beat, its own or an older stalled one
  `DPCM_ASSERT(a_in_to_out, (in_tvalid && in_tready) |-> ##2 out_tvalid)

  // reported bit count is one that some coding produces
  `DPCM_NEVER(a_bits_legal, out_tvalid && bits_bad)

endmodule

bind dpcm_audio_unit_decoder_core dpcm_chk u_dpcm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
